// ----- design/tplc_pkg.sv -----
package tplc_pkg;

    localparam int unsigned TAB_STOP = 8;

    localparam int unsigned BYTES_W = 32;
    localparam int unsigned COL_W   = 9;
    localparam int unsigned TOTAL_W = 31;
    localparam int unsigned PROD_W  = 39;
    localparam int unsigned DVS_W   = 37;
    localparam int unsigned PCT_W   = 7;

    localparam logic [1:0] OP_TEXT = 2'd0;
    localparam logic [1:0] OP_KEY  = 2'd1;
    localparam logic [1:0] OP_EOS  = 2'd2;

    localparam logic [1:0] KIND_EMIT   = 2'd0;
    localparam logic [1:0] KIND_PROMPT = 2'd1;
    localparam logic [1:0] KIND_QUIT   = 2'd2;

    localparam logic [1:0] REG_ROWS   = 2'd0;
    localparam logic [1:0] REG_COLS   = 2'd1;
    localparam logic [1:0] REG_PAGING = 2'd2;
    localparam logic [1:0] REG_TOTAL  = 2'd3;

    localparam logic [7:0] RST_ROWS = 8'd24;
    localparam logic [7:0] RST_COLS = 8'd80;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_Q_UP  = 8'h51;
    localparam logic [7:0] CH_Q_LO  = 8'h71;

    localparam logic [6:0] PCT_FULL = 7'd100;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DINIT,
        S_DSTEP,
        S_PCT
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic commit;
        logic mul;
        logic dinit;
        logic dstep;
        logic load_pct;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic ask;
        logic pct_needed;
        logic div_done;
    } t_stat;

    typedef struct packed {
        logic        en;
        logic [1:0]  idx;
        logic [31:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [7:0]         rows;
        logic [7:0]         cols;
        logic               paging;
        logic [TOTAL_W-1:0] total;
    } t_cfg_rd;

    function automatic logic [7:0] page_lines(input logic [7:0] rows);
        logic [7:0] r;
        r = (rows < 8'd2) ? 8'd2 : rows;
        return r - 8'd1;
    endfunction

endpackage

// ----- design/tplc_ctrl.sv -----
module tplc_ctrl
    import tplc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = (i_stat.ask && i_stat.pct_needed) ? S_MUL : S_IDLE;
                end
            end
            S_MUL:   n_state = S_DINIT;
            S_DINIT: n_state = S_DSTEP;
            S_DSTEP: begin
                if (i_stat.div_done) begin
                    n_state = S_PCT;
                end
            end
            S_PCT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            S_EXEC:  o_cmd.commit   = i_stat.out_free;
            S_MUL:   o_cmd.mul      = 1'b1;
            S_DINIT: o_cmd.dinit    = 1'b1;
            S_DSTEP: o_cmd.dstep    = 1'b1;
            S_PCT:   o_cmd.load_pct = i_stat.out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

`ifndef SYNTHESIS
    a_pct_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PCT) |-> ($past(r_state) == S_DSTEP || $past(r_state) == S_PCT))
        else $error("percentage state entered without a division");
    a_mul_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> ($past(r_state) == S_EXEC && $past(i_stat.ask)))
        else $error("multiply started without a prompt");
`endif

endmodule

// ----- design/tplc_dp.sv -----
module tplc_dp
    import tplc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_stat         o_stat,
    input  t_cfg_wr       i_cfg_wr,
    output t_cfg_rd       o_cfg_rd,
    input  logic [1:0]    i_opcode,
    input  logic [7:0]    i_byte_value,
    input  logic          i_stream_start,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [1:0]    o_result_kind,
    output logic [7:0]    o_out_byte,
    output logic          o_percent_known,
    output logic [6:0]    o_percent_done
);

    logic [7:0]         r_rows;
    logic [7:0]         r_cols;
    logic               r_paging;
    logic [TOTAL_W-1:0] r_total;

    logic [1:0] r_op;
    logic [7:0] r_byte;
    logic       r_start;

    logic [COL_W-1:0]   r_col,   n_col;
    logic [7:0]         r_left,  n_left;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic               r_wait,  n_wait;
    logic [7:0]         r_held,  n_held;
    logic               r_haw,   n_haw;
    logic               r_quit,  n_quit;

    logic [PROD_W-1:0] r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [PCT_W-1:0]  r_quo;
    logic              r_ovf;
    logic [2:0]        r_dcnt;

    logic       r_ov;
    logic [1:0] r_kind;
    logic [7:0] r_obyte;
    logic       r_known;
    logic [6:0] r_pct;

    logic       ex_res;
    logic       ex_ask;
    logic [1:0] ex_kind;
    logic [7:0] ex_obyte;

    logic [7:0] pl;
    logic [7:0] wc;
    logic       out_free;
    logic       load_ex;
    logic       step_ge;
    logic [6:0] pct_val;

    assign pl       = page_lines(r_rows);
    assign wc       = (r_cols < 8'd2) ? 8'd2 : r_cols;
    assign out_free = !r_ov || i_out_ready;

    always_comb begin
        logic [7:0]         c;
        logic [COL_W-1:0]   col;
        logic [7:0]         left;
        logic [BYTES_W-1:0] bcnt;
        logic [COL_W:0]     tab_sum;
        logic               do_run;
        logic               do_fin;
        c        = r_byte;
        col      = r_col;
        left     = r_left;
        bcnt     = r_bytes;
        tab_sum  = '0;
        do_run   = 1'b0;
        do_fin   = 1'b0;
        n_wait   = r_wait;
        n_held   = r_held;
        n_haw    = r_haw;
        n_quit   = r_quit;
        ex_res   = 1'b0;
        ex_ask   = 1'b0;
        ex_kind  = KIND_EMIT;
        ex_obyte = 8'h00;
        if (!r_quit) begin
            case (r_op)
                OP_TEXT: begin
                    if (!r_wait) begin
                        if (r_start) begin
                            bcnt = '0;
                            col  = '0;
                            if (left == 8'd0) begin
                                left = pl;
                            end
                        end
                        if (r_paging && left == 8'd0) begin
                            ex_ask = 1'b1;
                            n_held = r_byte;
                            n_haw  = 1'b0;
                        end else begin
                            do_run = 1'b1;
                        end
                    end
                end
                OP_KEY: begin
                    if (r_wait) begin
                        n_wait = 1'b0;
                        if (r_byte inside {CH_Q_LO, CH_Q_UP, CH_ETX}) begin
                            n_quit  = 1'b1;
                            ex_res  = 1'b1;
                            ex_kind = KIND_QUIT;
                        end else begin
                            left = (r_byte == CH_CR || r_byte == CH_LF) ? 8'd1 : pl;
                            c    = r_held;
                            if (r_haw) begin
                                do_fin = 1'b1;
                            end else begin
                                do_run = 1'b1;
                            end
                        end
                    end
                end
                OP_EOS: begin
                    if (!r_wait && col != '0) begin
                        col = '0;
                        if (r_paging && left != 8'd0) begin
                            left = left - 8'd1;
                        end
                        ex_res   = 1'b1;
                        ex_obyte = CH_LF;
                    end
                end
                default: ;
            endcase
            if (do_run) begin
                bcnt = bcnt + 1'b1;
                case (c)
                    CH_LF: begin
                        col = '0;
                        if (r_paging && left != 8'd0) begin
                            left = left - 8'd1;
                        end
                        ex_res   = 1'b1;
                        ex_obyte = c;
                    end
                    CH_CR: begin
                        col      = '0;
                        ex_res   = 1'b1;
                        ex_obyte = c;
                    end
                    CH_BS: begin
                        if (col != '0) begin
                            col = col - 1'b1;
                        end
                        ex_res   = 1'b1;
                        ex_obyte = c;
                    end
                    default: begin
                        if (col >= {1'b0, wc}) begin
                            col = '0;
                            if (r_paging && left != 8'd0) begin
                                left = left - 8'd1;
                            end
                            if (r_paging && left == 8'd0) begin
                                ex_ask = 1'b1;
                                n_held = c;
                                n_haw  = 1'b1;
                            end else begin
                                do_fin = 1'b1;
                            end
                        end else begin
                            do_fin = 1'b1;
                        end
                    end
                endcase
            end
            if (do_fin) begin
                if (c == CH_HT) begin
                    tab_sum = {1'b0, col} + (COL_W + 1)'(TAB_STOP);
                    tab_sum = tab_sum - (tab_sum % (COL_W + 1)'(TAB_STOP));
                    col     = tab_sum[COL_W-1:0];
                end else if (c >= CH_SPACE) begin
                    col = col + 1'b1;
                end
                ex_res   = 1'b1;
                ex_obyte = c;
            end
            if (ex_ask) begin
                n_wait   = 1'b1;
                ex_res   = 1'b1;
                ex_kind  = KIND_PROMPT;
                ex_obyte = 8'h00;
            end
        end
        n_col   = col;
        n_left  = left;
        n_bytes = bcnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= RST_ROWS;
            r_cols   <= RST_COLS;
            r_paging <= 1'b1;
            r_total  <= '0;
            r_col    <= '0;
            r_left   <= page_lines(RST_ROWS);
            r_bytes  <= '0;
            r_wait   <= 1'b0;
            r_held   <= '0;
            r_haw    <= 1'b0;
            r_quit   <= 1'b0;
        end else if (i_cfg_wr.en) begin
            unique case (i_cfg_wr.idx)
                REG_ROWS: begin
                    r_rows <= i_cfg_wr.data[7:0];
                    if (!r_wait) begin
                        r_left <= page_lines(i_cfg_wr.data[7:0]);
                    end
                end
                REG_COLS:   r_cols   <= i_cfg_wr.data[7:0];
                REG_PAGING: r_paging <= i_cfg_wr.data[0];
                REG_TOTAL:  r_total  <= i_cfg_wr.data[TOTAL_W-1:0];
                default: ;
            endcase
        end else if (i_cmd.commit) begin
            r_col   <= n_col;
            r_left  <= n_left;
            r_bytes <= n_bytes;
            r_wait  <= n_wait;
            r_held  <= n_held;
            r_haw   <= n_haw;
            r_quit  <= n_quit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op    <= i_opcode;
            r_byte  <= i_byte_value;
            r_start <= i_stream_start;
        end
    end

    assign step_ge = r_rem >= PROD_W'(r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.dinit) begin
            r_dcnt <= 3'(PCT_W - 1);
        end else if (i_cmd.dstep) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_rem <= PROD_W'(r_bytes) * PROD_W'(PCT_FULL);
        end else if (i_cmd.dstep && step_ge) begin
            r_rem <= r_rem - PROD_W'(r_dvs);
        end
        if (i_cmd.dinit) begin
            r_ovf <= r_rem >= PROD_W'({r_total, 7'b0});
            r_dvs <= {r_total, 6'b0};
            r_quo <= '0;
        end else if (i_cmd.dstep) begin
            r_dvs <= r_dvs >> 1;
            r_quo <= {r_quo[PCT_W-2:0], step_ge};
        end
    end

    assign pct_val = (r_ovf || r_quo > PCT_FULL) ? PCT_FULL : r_quo;
    assign load_ex = i_cmd.commit && ex_res && !(ex_ask && r_total != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_ex || i_cmd.load_pct) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ex) begin
            r_kind  <= ex_kind;
            r_obyte <= ex_obyte;
            r_known <= 1'b0;
            r_pct   <= '0;
        end else if (i_cmd.load_pct) begin
            r_kind  <= KIND_PROMPT;
            r_obyte <= 8'h00;
            r_known <= 1'b1;
            r_pct   <= pct_val;
        end
    end

    assign o_stat.out_free   = out_free;
    assign o_stat.ask        = ex_ask;
    assign o_stat.pct_needed = r_total != '0;
    assign o_stat.div_done   = r_dcnt == 3'd0;

    assign o_cfg_rd.rows   = r_rows;
    assign o_cfg_rd.cols   = r_cols;
    assign o_cfg_rd.paging = r_paging;
    assign o_cfg_rd.total  = r_total;

    assign o_out_valid     = r_ov;
    assign o_result_kind   = r_kind;
    assign o_out_byte      = r_obyte;
    assign o_percent_known = r_known;
    assign o_percent_done  = r_pct;

`ifndef SYNTHESIS
    a_no_wait_after_quit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_quit && r_wait))
        else $error("key awaited after quit");
    a_left_in_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= pl)
        else $error("lines left exceed a page");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_ex || i_cmd.load_pct) |-> (!r_ov || i_out_ready))
        else $error("pending result overwritten");
`endif

endmodule

// ----- design/text_pager_line_wrap_counter_top.sv -----
// Pager line counter: text bytes are passed through one item at a time while the display
// column and the lines left on the page are tracked; at a page end in paged mode the byte
// is held and a prompt item is returned, and the next key item refills the page or a line
// or quits. A text, key or end-of-stream item is latched into the input registers, and its
// column and line update is then committed together with the load of its result, if any.
// A prompt with a known stream size goes through the latch and update steps, a multiply
// step, a restoring divider (one setup step, then one quotient bit per cycle for seven
// bits) and a step that loads the result register. The result register frees the input
// side, so a new item is accepted while a result waits; that item then stays in its
// update state until the waiting result is taken.
module text_pager_line_wrap_counter_top
    import tplc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_byte_value,
    input  logic        i_stream_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_percent_known,
    output logic [6:0]  o_percent_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd    cmd;
    t_stat   stat;
    t_cfg_wr cfg_wr;
    t_cfg_rd cfg_rd;

    assign pready      = 1'b1;
    assign cfg_wr.en   = psel && penable && pwrite;
    assign cfg_wr.idx  = paddr[3:2];
    assign cfg_wr.data = pwdata;

    always_comb begin
        unique case (paddr[3:2])
            REG_ROWS:   prdata = {24'd0, cfg_rd.rows};
            REG_COLS:   prdata = {24'd0, cfg_rd.cols};
            REG_PAGING: prdata = {31'd0, cfg_rd.paging};
            REG_TOTAL:  prdata = {1'b0, cfg_rd.total};
            default:    prdata = '0;
        endcase
    end

    tplc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tplc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_wr        (cfg_wr),
        .o_cfg_rd        (cfg_rd),
        .i_opcode        (i_opcode),
        .i_byte_value    (i_byte_value),
        .i_stream_start  (i_stream_start),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_out_byte      (o_out_byte),
        .o_percent_known (o_percent_known),
        .o_percent_done  (o_percent_done)
    );

endmodule
